/* rtl/ptte_pkg.sv */
// Package of the polynomial term table evaluator: command and status codes,
// the controller/datapath command and status structs and the default table depth.
// No dependencies.
`default_nettype none

package ptte_pkg;

	localparam int MAX_DEG_DEF = 64;

	// Input command codes.
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_EVAL  = 2'd1;
	localparam logic [1:0] CMD_DERIV = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAXPOS64 = 64'h7FFF_FFFF_FFFF_FFFF;

	// Controller to datapath strobes.
	typedef struct packed {
		logic capture;   // take the input beat
		logic prime;     // read slot prefetch
		logic mul;       // Horner multiply phase
		logic cmb;       // product combine and round phase
		logic acc;       // accumulate phase
		logic upd;       // add-term update of one slot
		logic load_out;  // move the finished result to the output register
	} ptte_ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic exp_ok;    // exponent of the offered beat is inside the table
		logic last;      // Horner step now in flight is the final one
	} ptte_stat_t;

endpackage

`default_nettype wire

/* rtl/ptte_if.sv */
// Valid/ready channel interfaces for request and response beats of the evaluator.
// Depends on nothing beyond the language; widths are fixed by the command format.
`default_nettype none

interface ptte_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  cmd;
	logic signed [31:0] coefficient;
	logic        [7:0]  exponent;
	logic signed [15:0] x_value;

	modport source (output valid, cmd, coefficient, exponent, x_value, input ready);
	modport sink   (input valid, cmd, coefficient, exponent, x_value, output ready);
endinterface

interface ptte_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] result_value;
	logic        [1:0]  status;

	modport source (output valid, result_value, status, input ready);
	modport sink   (input valid, result_value, status, output ready);
endinterface

`default_nettype wire

/* rtl/ptte_ctrl.sv */
// Sequencer of the evaluator: decodes each request beat and steps the datapath.
// Depends on ptte_pkg.
`default_nettype none

module ptte_ctrl import ptte_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic [1:0] req_cmd,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	input  wire ptte_stat_t stat,
	output ptte_ctl_t       ctl
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PRIME = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_CMB   = 3'd3;
	localparam logic [2:0] S_ACC   = 3'd4;
	localparam logic [2:0] S_UPD   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       is_add_q, is_add_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d  = state_q;
		is_add_d = is_add_q;
		ctl      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.capture = 1'b1;
					is_add_d    = (req_cmd == CMD_ADD);
					unique case (req_cmd)
						CMD_ADD:   state_d = stat.exp_ok ? S_PRIME : S_DONE;
						CMD_EVAL:  state_d = S_PRIME;
						CMD_DERIV: state_d = S_PRIME;
						CMD_CLEAR: state_d = S_DONE;
					endcase
				end
			end
			S_PRIME: begin
				ctl.prime = 1'b1;
				state_d   = is_add_q ? S_UPD : S_MUL;
			end
			S_MUL: begin
				ctl.mul = 1'b1;
				state_d = S_CMB;
			end
			S_CMB: begin
				ctl.cmb = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				ctl.acc = 1'b1;
				state_d = stat.last ? S_DONE : S_MUL;
			end
			S_UPD: begin
				ctl.upd = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			is_add_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			is_add_q <= is_add_d;
			if (ctl.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/ptte_dp.sv */
// Datapath of the evaluator: coefficient memory with per-slot valid bits, the
// Horner multiply/round/accumulate pipeline, slot update and result registers.
// Depends on ptte_pkg.
`default_nettype none

module ptte_dp import ptte_pkg::*; #(
	parameter int MAX_DEG = MAX_DEG_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ptte_ctl_t          ctl,
	output ptte_stat_t              stat,
	input  wire logic        [1:0]  cmd,
	input  wire logic signed [31:0] coefficient,
	input  wire logic        [7:0]  exponent,
	input  wire logic signed [15:0] x_value,
	output logic signed      [63:0] result_value,
	output logic             [1:0]  status
);

	localparam int IW = $clog2(MAX_DEG);
	localparam int PW = 33 + IW;   // width of the k * c_k product
	localparam logic [47:0] HI_LIM = 48'h0800_0000_0000;

	// Coefficient store.
	logic [31:0]         coef_mem_q [MAX_DEG];
	logic [MAX_DEG-1:0]  valid_q;
	logic [31:0]         rd_mem_q;
	logic                rd_valid_q;
	logic signed [31:0]  rd_coef;

	// Captured request.
	logic signed [31:0]  coef_q;
	logic                x_neg_q;
	logic [15:0]         x_mag_q;
	logic                deriv_q;
	logic [IW-1:0]       k_q;
	logic [IW-1:0]       k_stop;

	// Horner pipeline.
	logic [63:0]         acc_q;
	logic                sat_q;
	logic [63:0]         acc_mag;
	logic [47:0]         hi_c;
	logic [48:0]         lo_c;
	logic [47:0]         hi_s1;
	logic [48:0]         lo_s1;
	logic                neg_s1;
	logic signed [31:0]  coef_s1;
	logic [IW-1:0]       kt_s1;
	logic                last_s1;
	logic [63:0]         q_c;
	logic [63:0]         limit_c;
	logic                psat_c;
	logic signed [PW-1:0] term_c;
	logic [63:0]         mag_s2;
	logic                neg_s2;
	logic                sat_s2;
	logic signed [PW-1:0] term_s2;
	logic [63:0]         term64;
	logic [64:0]         t65;
	logic [64:0]         m65;
	logic [64:0]         sum65;
	logic                acc_ovf;
	logic [63:0]         acc_new;
	logic                acc_sat;

	// Slot update.
	logic [32:0]         s33;
	logic                upd_ovf;
	logic [31:0]         upd_val;

	// Results.
	logic [63:0]         res_value_q;
	logic [1:0]          res_status_q;
	logic [63:0]         out_value_q;
	logic [1:0]          out_status_q;

	assign stat.exp_ok = ({1'b0, exponent} < 9'(MAX_DEG));
	assign stat.last   = last_s1;
	assign rd_coef     = rd_valid_q ? $signed(rd_mem_q) : 32'sd0;
	assign k_stop      = deriv_q ? IW'(1) : '0;

	// Multiply phase: magnitude of the accumulator times |x|, in two halves.
	assign acc_mag = acc_q[63] ? (~acc_q + 64'd1) : acc_q;
	assign hi_c    = 48'(acc_mag[63:32]) * 48'(x_mag_q);
	assign lo_c    = 49'(acc_mag[31:0]) * 49'(x_mag_q) + 49'd2048;

	// Combine phase: rounded quotient by 4096 and the magnitude clamp.
	assign q_c     = {hi_s1[43:0], 20'd0} + {27'd0, lo_s1[48:12]};
	assign limit_c = neg_s1 ? SIGN64 : MAXPOS64;
	assign psat_c  = (hi_s1 > HI_LIM) || (q_c > limit_c);
	assign term_c  = deriv_q ? (PW'(coef_s1) * PW'($signed({1'b0, kt_s1}))) : PW'(coef_s1);

	// Accumulate phase: signed add of the product and the term, one saturation.
	assign term64  = {{(52 - PW){term_s2[PW-1]}}, term_s2, 12'd0};
	assign t65     = {term64[63], term64};
	assign m65     = {1'b0, mag_s2};
	assign sum65   = neg_s2 ? (t65 - m65) : (t65 + m65);
	assign acc_ovf = sum65[64] ^ sum65[63];
	assign acc_new = acc_ovf ? (sum65[64] ? SIGN64 : MAXPOS64) : sum65[63:0];
	assign acc_sat = sat_q || sat_s2 || acc_ovf;

	// Slot update with 32-bit saturation.
	assign s33     = {rd_coef[31], rd_coef} + {coef_q[31], coef_q};
	assign upd_ovf = s33[32] ^ s33[31];
	assign upd_val = upd_ovf ? (s33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : s33[31:0];

	always_ff @(posedge clk) begin
		rd_mem_q <= coef_mem_q[k_q];
		if (ctl.upd) begin
			coef_mem_q[k_q] <= upd_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[k_q];
			if (ctl.capture && (cmd == CMD_CLEAR)) begin
				valid_q <= '0;
			end else if (ctl.upd) begin
				valid_q[k_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			coef_q  <= coefficient;
			x_neg_q <= x_value[15];
			x_mag_q <= x_value[15] ? (~x_value + 16'd1) : x_value;
			deriv_q <= (cmd == CMD_DERIV);
			acc_q   <= '0;
			sat_q   <= 1'b0;
			k_q     <= (cmd == CMD_ADD) ? exponent[IW-1:0] : IW'(MAX_DEG - 1);
			res_value_q  <= '0;
			res_status_q <= ((cmd == CMD_ADD) && !stat.exp_ok) ? ST_RANGE : ST_OK;
		end
		if (ctl.mul) begin
			hi_s1   <= hi_c;
			lo_s1   <= lo_c;
			neg_s1  <= acc_q[63] ^ x_neg_q;
			coef_s1 <= rd_coef;
			kt_s1   <= k_q;
			last_s1 <= (k_q == k_stop);
			if (k_q != k_stop) begin
				k_q <= k_q - IW'(1);
			end
		end
		if (ctl.cmb) begin
			mag_s2  <= psat_c ? limit_c : q_c;
			neg_s2  <= neg_s1;
			sat_s2  <= psat_c;
			term_s2 <= term_c;
		end
		if (ctl.acc) begin
			acc_q <= acc_new;
			sat_q <= acc_sat;
			if (last_s1) begin
				res_value_q  <= acc_new;
				res_status_q <= acc_sat ? ST_SAT : ST_OK;
			end
		end
		if (ctl.upd) begin
			res_value_q  <= {{32{upd_val[31]}}, upd_val};
			res_status_q <= upd_ovf ? ST_SAT : ST_OK;
		end
		if (ctl.load_out) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	assign result_value = $signed(out_value_q);
	assign status       = out_status_q;

	// The prime strobe only marks the prefetch cycle; the memory reads every cycle.
	logic unused_prime;
	assign unused_prime = ctl.prime;

endmodule

`default_nettype wire

/* rtl/polynomial_term_table_evaluator.sv */
// Top level of the polynomial term table evaluator: joins the sequencer and the
// datapath to the request and response channels. Depends on ptte_pkg, ptte_if,
// ptte_ctrl and ptte_dp.
`default_nettype none

// Usage
// The req channel carries one command per beat: add a coefficient into the slot
// of its exponent, evaluate the polynomial at x (Q4.12), evaluate its derivative
// at x, or clear the table. Every request beat yields exactly one rsp beat with
// result_value (Q.12 for evaluations, the new slot value for add-term, zero for
// clear and for an out-of-range exponent) and status.
// The block works on one request at a time; req.ready is high while it is idle,
// even when an earlier response still waits for rsp.ready.
// After acceptance, clear and out-of-range add go straight to the done state and
// add-term passes the prime and update states; evaluate and derivative prime the read,
// then run one Horner step per slot from the top slot down to 0 (1 for the derivative).
// Each Horner step walks the shared multiply, combine/round and accumulate phases once,
// so the evaluation time is set by that three-phase loop over the coefficient memory.
// Reset clears the per-slot valid bits, so the table reads as all zero at once,
// with no clearing sweep; clear does the same.
// When the receiver stalls, the finished result stays in the output register and
// a following result waits in the datapath until that beat is taken.

module polynomial_term_table_evaluator import ptte_pkg::*; #(
	parameter int MAX_DEG = MAX_DEG_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ptte_req_if.sink    req,
	ptte_rsp_if.source  rsp
);

	ptte_ctl_t  ctl;
	ptte_stat_t stat;

	ptte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_cmd   (req.cmd),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	ptte_dp #(
		.MAX_DEG (MAX_DEG)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.cmd          (req.cmd),
		.coefficient  (req.coefficient),
		.exponent     (req.exponent),
		.x_value      (req.x_value),
		.result_value (rsp.result_value),
		.status       (rsp.status)
	);

	// A Horner step always runs multiply, combine and accumulate in that order.
	a_mul_then_cmb: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mul |=> ctl.cmb)
		else $error("multiply phase not followed by combine phase");

	a_cmb_then_acc: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmb |=> ctl.acc)
		else $error("combine phase not followed by accumulate phase");

	// A result is never written over one that the receiver has not yet taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!rsp.valid || rsp.ready))
		else $error("output register loaded while a response beat is pending");

	// Every accepted beat makes the block busy, so no request is taken in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted in back-to-back cycles");

endmodule

`default_nettype wire

/* sim/tb_polynomial_term_table_evaluator.sv */
// Self-checking bench for the polynomial term table evaluator: random valid/ready
// traffic on both channels, every response checked against an in-bench table model.
// Depends on ptte_pkg, ptte_if and the polynomial_term_table_evaluator RTL.
`default_nettype none

module tb_polynomial_term_table_evaluator;
	import ptte_pkg::*;

	localparam int MAX_DEG = MAX_DEG_DEF;
	// The stimulus stops growing once this many commands are queued.
	localparam int TOTAL_COMMANDS = 925;

	localparam logic signed [63:0] COEF_MAX = 64'sd2147483647;
	localparam logic signed [63:0] COEF_MIN = -64'sd2147483648;

	typedef struct packed {
		logic        [1:0]  cmd;
		logic signed [31:0] coefficient;
		logic        [7:0]  exponent;
		logic signed [15:0] x_value;
	} poly_cmd_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic        [1:0]  status;
	} poly_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ptte_req_if req ();
	ptte_rsp_if rsp ();

	polynomial_term_table_evaluator #(
		.MAX_DEG(MAX_DEG)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Bench copy of the coefficient table; it tracks the block beat by beat.
	logic signed [31:0] coef_table_model [MAX_DEG];

	poly_cmd_t    command_queue [$];
	poly_result_t expected_results [$];

	int mismatches = 0;

	// Driver and receiver bookkeeping.
	logic         req_taken = 1'b0;
	int           send_idle_left = 0;
	int           send_calm = 0;
	int           stall_left = 0;
	int           stall_len = 0;
	int           stall_calm = 0;
	poly_cmd_t    next_cmd;
	poly_result_t want;

	// Q.12 product of the accumulator and a Q4.12 point, rounded to nearest with
	// ties away from zero on the magnitude, then clamped to the 64-bit range.
	function automatic logic signed [63:0] q12_mul(input logic signed [63:0] acc,
			input logic signed [15:0] x, inout bit clamped);
		logic signed [127:0] prod;
		logic        [127:0] mag;
		logic        [127:0] q;
		logic                neg;
		neg = acc[63] ^ x[15];
		prod = $signed({{64{acc[63]}}, acc}) * $signed({{112{x[15]}}, x});
		mag = prod[127] ? -prod : prod;
		q = (mag + 128'd2048) >> 12;
		if (q > (neg ? {64'd0, SIGN64} : {64'd0, MAXPOS64})) begin
			clamped = 1'b1;
			return neg ? SIGN64 : MAXPOS64;
		end
		return neg ? -q[63:0] : q[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
			input logic signed [63:0] b, inout bit clamped);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			clamped = 1'b1;
			return a[63] ? SIGN64 : MAXPOS64;
		end
		return s;
	endfunction

	// Horner walk over the table from the top slot down. The derivative scales
	// each coefficient by its exponent and stops before the constant term.
	function automatic logic signed [63:0] horner(input bit deriv,
			input logic signed [15:0] x, output bit clamped);
		logic signed [63:0] acc;
		logic signed [63:0] term;
		int                 lowest;
		int                 k;
		clamped = 1'b0;
		acc = '0;
		lowest = deriv ? 1 : 0;
		for (k = MAX_DEG - 1; k >= lowest; k--) begin
			term = {{32{coef_table_model[k][31]}}, coef_table_model[k]};
			if (deriv)
				term = term * 64'(k);
			term = term <<< 12;
			acc = q12_mul(acc, x, clamped);
			acc = sat_sum(acc, term, clamped);
		end
		return acc;
	endfunction

	// Carries out one command on the model table and returns its response.
	function automatic poly_result_t apply_command(input logic [1:0] cmd,
			input logic signed [31:0] coefficient, input logic [7:0] exponent,
			input logic signed [15:0] x_value);
		poly_result_t       res;
		logic signed [63:0] sum;
		bit                 clamped;
		res.value = '0;
		res.status = ST_OK;
		case (cmd)
			CMD_ADD: begin
				if (int'(exponent) >= MAX_DEG) begin
					res.status = ST_RANGE;
				end else begin
					sum = {{32{coef_table_model[exponent][31]}}, coef_table_model[exponent]}
						+ {{32{coefficient[31]}}, coefficient};
					if (sum > COEF_MAX) begin
						sum = COEF_MAX;
						res.status = ST_SAT;
					end else if (sum < COEF_MIN) begin
						sum = COEF_MIN;
						res.status = ST_SAT;
					end
					coef_table_model[exponent] = sum[31:0];
					res.value = sum;
				end
			end
			CMD_EVAL, CMD_DERIV: begin
				res.value = horner(cmd == CMD_DERIV, x_value, clamped);
				if (clamped)
					res.status = ST_SAT;
			end
			default: begin
				foreach (coef_table_model[i])
					coef_table_model[i] = '0;
			end
		endcase
		return res;
	endfunction

	// Gap lengths: mostly none or short, a few long, and now and then a calm
	// stretch in which no gaps are inserted at all.
	function automatic int pick_gap(inout int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [31:0] random_coefficient();
		case ($urandom_range(0, 6))
			0, 1, 2: return $urandom_range(0, 200) - 100;
			3:       return $urandom_range(0, 131070) - 65535;
			4:       return $urandom;
			5:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
			default: return 32'h8000_0000 + $urandom_range(0, 3);
		endcase
	endfunction

	// Low exponents dominate so that evaluations stay mostly unsaturated.
	function automatic logic [7:0] random_exponent();
		int r;
		r = $urandom_range(0, 19);
		if (r < 11)
			return 8'($urandom_range(0, 7));
		if (r < 16)
			return 8'($urandom_range(0, MAX_DEG - 1));
		if (r < 18)
			return 8'($urandom_range(MAX_DEG - 4, MAX_DEG - 1));
		return 8'($urandom_range(MAX_DEG, 255));
	endfunction

	function automatic logic signed [15:0] random_x();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'($urandom_range(0, 8192) - 4096);
			4, 5, 6:    return 16'($urandom_range(0, 16384) - 8192);
			7, 8:       return 16'($urandom);
			default: begin
				case ($urandom_range(0, 4))
					0:       return 16'sh0000;
					1:       return 16'sh1000;
					2:       return -16'sh1000;
					3:       return 16'sh7FFF;
					default: return 16'sh8000;
				endcase
			end
		endcase
	endfunction

	task automatic queue_command(input logic [1:0] cmd, input logic signed [31:0] coefficient,
			input logic [7:0] exponent, input logic signed [15:0] x_value);
		command_queue.push_back('{cmd, coefficient, exponent, x_value});
	endtask

	// Fields that a command does not use still carry random values.
	task automatic queue_add(input logic signed [31:0] coefficient, input logic [7:0] exponent);
		queue_command(CMD_ADD, coefficient, exponent, 16'($urandom));
	endtask

	task automatic queue_eval(input logic [1:0] cmd, input logic signed [15:0] x_value);
		queue_command(cmd, $urandom, 8'($urandom_range(0, 255)), x_value);
	endtask

	task automatic queue_clear();
		queue_command(CMD_CLEAR, $urandom, 8'($urandom_range(0, 255)), 16'($urandom));
	endtask

	task automatic note_mismatch(input string what, input logic signed [63:0] expected,
			input logic signed [63:0] actual);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expected, actual);
	endtask

	// Request driver. A beat stays on the channel until it is taken; after that
	// the valid line may drop for the idle count chosen when the beat went out.
	always @(negedge clk) begin
		if (arst_n) begin
			if (req.valid && !req_taken) begin
				// Hold the current beat.
			end else if (send_idle_left > 0) begin
				req.valid <= 1'b0;
				send_idle_left <= send_idle_left - 1;
			end else if (command_queue.size() > 0) begin
				next_cmd = command_queue.pop_front();
				req.cmd <= next_cmd.cmd;
				req.coefficient <= next_cmd.coefficient;
				req.exponent <= next_cmd.exponent;
				req.x_value <= next_cmd.x_value;
				req.valid <= 1'b1;
				send_idle_left <= pick_gap(send_calm);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Response receiver: ready drops at random for stalls of random length, so
	// that stalls land on results waiting in the output register as well.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				stall_len = ($urandom_range(0, 3) == 0) ? pick_gap(stall_calm) : 0;
				rsp.ready <= (stall_len == 0);
				stall_left <= (stall_len > 0) ? stall_len - 1 : 0;
			end
		end
	end

	// Monitor. The response side is checked before a new request is predicted;
	// no response can leave on the edge that accepts its own request.
	always @(posedge clk) begin
		req_taken <= req.valid && req.ready;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					note_mismatch("unexpected response, result_value", '0, rsp.result_value);
				end else begin
					want = expected_results.pop_front();
					if (rsp.result_value !== want.value)
						note_mismatch("result_value", want.value, rsp.result_value);
					if (rsp.status !== want.status)
						note_mismatch("status", 64'(want.status), 64'(rsp.status));
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(apply_command(req.cmd, req.coefficient,
					req.exponent, req.x_value));
		end
	end

	initial begin
		req.valid = 1'b0;
		req.cmd = CMD_CLEAR;
		req.coefficient = '0;
		req.exponent = '0;
		req.x_value = '0;
		rsp.ready = 1'b0;
		foreach (coef_table_model[i])
			coef_table_model[i] = '0;

		// Directed opening: slot saturation both ways, a zero add, out-of-range
		// exponents, evaluation at the extreme points, clear, and a short
		// polynomial with known value and derivative.
		queue_add(32'sh7FFF_FFFF, 8'd0);
		queue_add(32'sd1, 8'd0);
		queue_add(32'sh8000_0000, 8'(MAX_DEG - 1));
		queue_add(-32'sd1, 8'(MAX_DEG - 1));
		queue_add(32'sd0, 8'd5);
		queue_add(32'sd5, 8'(MAX_DEG));
		queue_add(32'sd5, 8'd255);
		queue_eval(CMD_EVAL, 16'sh7FFF);
		queue_eval(CMD_EVAL, 16'sh8000);
		queue_eval(CMD_DERIV, 16'sh7FFF);
		queue_eval(CMD_DERIV, 16'sh8000);
		queue_eval(CMD_EVAL, 16'sh0000);
		queue_clear();
		queue_eval(CMD_EVAL, 16'sh1000);
		queue_add(32'sd7, 8'd0);
		queue_add(-32'sd5, 8'd1);
		queue_add(32'sd3, 8'd2);
		queue_eval(CMD_EVAL, 16'sh2000);
		queue_eval(CMD_DERIV, 16'sh2000);
		queue_eval(CMD_EVAL, -16'sh0800);
		queue_eval(CMD_DERIV, 16'sh0001);
		queue_add(-32'sd3, 8'd2);
		queue_eval(CMD_EVAL, -16'sh0001);
		queue_clear();

		// Random part: mostly whole polynomials (an optional clear, a few terms,
		// then evaluations), which also sums polynomials when the clear is
		// skipped; the rest is arbitrary commands with arbitrary fields.
		while (command_queue.size() < TOTAL_COMMANDS) begin
			if ($urandom_range(0, 9) < 8) begin
				if ($urandom_range(0, 3) != 0)
					queue_clear();
				repeat ($urandom_range(1, 8))
					queue_add(random_coefficient(), random_exponent());
				repeat ($urandom_range(1, 3))
					queue_eval($urandom_range(0, 1) ? CMD_EVAL : CMD_DERIV, random_x());
			end else begin
				repeat ($urandom_range(1, 4))
					queue_command(2'($urandom_range(0, 3)), $urandom,
						8'($urandom_range(0, 255)), 16'($urandom));
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (command_queue.size() != 0 || req.valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		// Give a stray extra response time to show up.
		repeat (3 * MAX_DEG + 10) @(posedge clk);

		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog: well beyond the slowest legal run of the whole stimulus.
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
